// ===== hdl/bod_pkg.sv =====
// shared types and constants for the BER OID to dotted text converter
// no dependencies; used by every module of the block
`default_nettype none

package bod_pkg;

  // one input transaction: an OID contents byte and its end marker
  typedef struct packed {
    logic [7:0] enc_byte;
    logic       last_byte;
  } in_t;

  // one result transaction: a single character of the dotted text
  typedef struct packed {
    logic [5:0] char_code;
    logic       run_last;
    logic       oid_end;
  } out_t;

  // flags that travel with a finished subidentifier through the job queue
  typedef struct packed {
    logic first;
    logic last;
  } job_flags_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] CH_ZERO = 6'd48;
  localparam logic [5:0] CH_DOT  = 6'd46;

  localparam logic [6:0] PAYLOAD_MASK = 7'h7f;

endpackage

`default_nettype wire

// ===== hdl/ber_oid_to_dotted_text.sv =====
// BER object identifier to dotted decimal text: top level
// continuation bytes are absorbed into the accumulator
// a closing byte is queued; the generator then does binary to bcd conversion
// (4 bits a cycle) and emits the resulting characters in order
// synchronous active-low reset returns to the start of a new OID, queue empty
// uses bod_pkg, bod_front, bod_queue, bod_back
`default_nettype none

module ber_oid_to_dotted_text #(
  parameter int NODE_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bod_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bod_pkg::out_t       out_data
);

  localparam int FLAGS_W = $bits(bod_pkg::job_flags_t);
  localparam int JOB_W   = NODE_BITS + FLAGS_W;

  logic                 q_full, q_empty;
  logic                 push, pop;
  logic [NODE_BITS-1:0] push_value;
  bod_pkg::job_flags_t  push_flags;
  logic [JOB_W-1:0]     pop_data;
  bod_pkg::job_flags_t  job_flags;
  logic [NODE_BITS-1:0] job_value;

  assign job_flags = bod_pkg::job_flags_t'(pop_data[JOB_W-1 -: FLAGS_W]);
  assign job_value = pop_data[NODE_BITS-1:0];

  bod_front #(
    .NODE_BITS (NODE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_value (push_value),
    .push_flags (push_flags)
  );

  bod_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_flags, push_value}),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bod_back #(
    .NODE_BITS (NODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop       (pop),
    .job_value (job_value),
    .job_flags (job_flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/bod_front.sv =====
// front end: accepts OID bytes, builds base-128 subidentifiers and
// pushes each finished one as a job; depends on bod_pkg
`default_nettype none

module bod_front #(
  parameter int NODE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire bod_pkg::in_t          in_data,
  input  wire logic                  q_full,
  output logic                       push,
  output logic [NODE_BITS-1:0]       push_value,
  output bod_pkg::job_flags_t        push_flags
);

  logic [NODE_BITS-1:0] accum_r, accum_nxt;
  logic                 first_done_r, first_done_nxt;
  logic [NODE_BITS-1:0] sum;
  logic                 accept;
  logic                 cont;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign sum      = accum_r + NODE_BITS'(in_data.enc_byte[6:0] & bod_pkg::PAYLOAD_MASK);
  // continuation bytes only shift; the last byte always closes the subidentifier
  assign cont     = in_data.enc_byte[7] && !in_data.last_byte;

  always_comb begin
    accum_nxt        = accum_r;
    first_done_nxt   = first_done_r;
    push             = 1'b0;
    push_value       = sum;
    push_flags.first = !first_done_r;
    push_flags.last  = in_data.last_byte;
    if (accept) begin
      if (cont) begin
        accum_nxt = {sum[NODE_BITS-8:0], 7'b0};
      end else begin
        push           = 1'b1;
        accum_nxt      = '0;
        first_done_nxt = !in_data.last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      first_done_r <= 1'b0;
    end else begin
      accum_r      <= accum_nxt;
      first_done_r <= first_done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bod_queue.sv =====
// short job queue between the front end and the text generator
// depends on bod_pkg for its depth
`default_nettype none

module bod_queue #(
  parameter int DATA_W = 34
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   full,
  output logic                   empty
);

  localparam int DEPTH = bod_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bod_back.sv =====
// back end: turns queued subidentifiers into ASCII decimal characters
// iterative binary to bcd conversion, 4 bits a cycle; depends on bod_pkg
`default_nettype none

module bod_back #(
  parameter int NODE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  output logic                       pop,
  input  wire logic [NODE_BITS-1:0]  job_value,
  input  wire bod_pkg::job_flags_t   job_flags,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output bod_pkg::out_t              out_data
);

  localparam int STEPS  = (NODE_BITS + 3) / 4;
  localparam int BIN_W  = STEPS * 4;
  localparam int DIGITS = (NODE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int STEP_W = $clog2(STEPS);
  localparam int IDX_W  = $clog2(DIGITS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CONV = 7'b0000010,
    S_FIND = 7'b0000100,
    S_PFX  = 7'b0001000,
    S_PDOT = 7'b0010000,
    S_DIG  = 7'b0100000,
    S_DOT  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [BIN_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [1:0]          x_r, x_nxt;
  logic                first_r, first_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  bod_pkg::out_t       out_data_r, out_data_nxt;

  logic                adv;
  logic                emit;
  bod_pkg::out_t       emit_data;
  logic [BCD_W-1:0]    dab;
  logic [IDX_W-1:0]    msd;
  logic [3:0]          digit_sel;
  logic [NODE_BITS-1:0] y_val;
  logic [1:0]          x_val;

  assign adv       = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign digit_sel = bcd_r[4*idx_r +: 4];

  // split of the first subidentifier into X.Y
  always_comb begin
    priority if (job_value <= NODE_BITS'(39)) begin
      x_val = 2'd0;
      y_val = job_value;
    end else if (job_value <= NODE_BITS'(79)) begin
      x_val = 2'd1;
      y_val = job_value - NODE_BITS'(40);
    end else begin
      x_val = 2'd2;
      y_val = job_value - NODE_BITS'(80);
    end
  end

  // double dabble over the next four binary bits
  always_comb begin
    dab = bcd_r;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (dab[4*d +: 4] >= 4'd5) begin
          dab[4*d +: 4] = dab[4*d +: 4] + 4'd3;
        end
      end
      dab = {dab[BCD_W-2:0], bin_r[BIN_W-1-b]};
    end
  end

  // most significant nonzero digit, zero when the value is zero
  always_comb begin
    msd = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[4*d +: 4] != 4'd0) begin
        msd = IDX_W'(d);
      end
    end
  end

  always_comb begin
    state_nxt          = state_r;
    bin_nxt            = bin_r;
    bcd_nxt            = bcd_r;
    step_nxt           = step_r;
    idx_nxt            = idx_r;
    x_nxt              = x_r;
    first_nxt          = first_r;
    last_nxt           = last_r;
    pop                = 1'b0;
    emit               = 1'b0;
    emit_data.char_code = bod_pkg::CH_DOT;
    emit_data.run_last = 1'b0;
    emit_data.oid_end  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          first_nxt = job_flags.first;
          last_nxt  = job_flags.last;
          x_nxt     = x_val;
          bin_nxt   = BIN_W'(job_flags.first ? y_val : job_value);
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt  = dab;
        bin_nxt  = bin_r << 4;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        idx_nxt   = msd;
        state_nxt = first_r ? S_PFX : S_DIG;
      end
      S_PFX: begin
        if (adv) begin
          emit                = 1'b1;
          emit_data.char_code = bod_pkg::CH_ZERO + {4'b0, x_r};
          state_nxt           = S_PDOT;
        end
      end
      S_PDOT: begin
        if (adv) begin
          emit      = 1'b1;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (adv) begin
          emit                = 1'b1;
          emit_data.char_code = bod_pkg::CH_ZERO + {2'b0, digit_sel};
          if (idx_r == '0) begin
            if (last_r) begin
              emit_data.run_last = 1'b1;
              emit_data.oid_end  = 1'b1;
              state_nxt          = S_IDLE;
            end else begin
              state_nxt = S_DOT;
            end
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      S_DOT: begin
        if (adv) begin
          emit               = 1'b1;
          emit_data.run_last = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: holds a character until the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    step_r     <= step_nxt;
    idx_r      <= idx_nxt;
    x_r        <= x_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire
